/* sv/sfms_pkg.sv */
// Package for the first-match substring search core: constants, types, helpers.
package sfms_pkg;

   localparam int unsigned MAX_PATTERN_DEF = 16;
   localparam int unsigned MAX_STRING_DEF  = 65536;
   localparam int unsigned PAT_BYTES       = 16;
   localparam int unsigned CSR_DATA_W      = 64;
   localparam int unsigned CSR_INDEX_W     = 2;
   localparam int unsigned PAT_LEN_W       = 5;
   localparam int unsigned INDEX_W         = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW  = 2'd0,
      CSR_PATTERN_HIGH = 2'd1,
      CSR_PATTERN_LEN  = 2'd2
   } csr_index_type;

   typedef logic [PAT_BYTES-1:0][7:0] pattern_type;

   function automatic logic [7:0] pat_byte(input pattern_type pat, input int unsigned i);
      logic [7:0] b;
      b = 8'd0;
      if (i < PAT_BYTES) begin
         b = pat[i[$clog2(PAT_BYTES)-1:0]];
      end
      return b;
   endfunction

endpackage

/* sv/substring_first_match_search_core.sv */
// Top level of the first-match substring search core.
//
// req_* carries a string one byte per transfer; req_tlast marks its final byte.
// csr_* writes the pattern registers: index 0 pattern bytes 0..7, index 1 bytes
// 8..15, index 2 pattern length (1..MAX_PATTERN). Write only while idle.
// rsp_* returns at most one result per string: tuser = found, tdata = start
// offset of the first match (0 when not found). A result appears when a match
// first completes, or at the last byte of a string with no match. Bytes after
// a match are consumed silently up to the last byte.
// A result is registered: the byte that causes it passes the input register,
// then the compare into the result register.
// Throughput: one byte per cycle; the window compare is a single parallel
// stage. When rsp_tready is low the result register holds, the input stage
// holds behind it, and req_tready drops once both are full.
// Reset (synchronous) empties both stages, clears the window, position and
// match flag, and sets the pattern to length 1, all bytes zero.
module substring_first_match_search_core #(
   parameter int unsigned MAX_PATTERN = sfms_pkg::MAX_PATTERN_DEF,
   parameter int unsigned MAX_STRING  = sfms_pkg::MAX_STRING_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // data_byte
   input  logic                                 req_tlast,   // last_byte
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [sfms_pkg::INDEX_W-1:0]         rsp_tdata,   // match_index
   output logic                                 rsp_tuser,   // found
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sfms_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sfms_pkg::CSR_DATA_W-1:0]      csr_data
);
   import sfms_pkg::*;

   localparam int unsigned LEN_W  = $clog2(MAX_PATTERN + 1);
   localparam int unsigned IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int unsigned POS_W  = $clog2(MAX_STRING + 2);
   localparam int unsigned DIFF_W = (POS_W > LEN_W) ? POS_W : LEN_W;

   // configuration registers
   logic [CSR_DATA_W-1:0] pat_low_ff, pat_high_ff;
   logic [PAT_LEN_W-1:0]  pat_len_ff;
   pattern_type           pattern;

   assign csr_ready = 1'b1;
   assign pattern   = pattern_type'({pat_high_ff, pat_low_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= PAT_LEN_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_data;
            CSR_PATTERN_HIGH: pat_high_ff <= csr_data;
            CSR_PATTERN_LEN:  pat_len_ff  <= csr_data[PAT_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // input stage
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;
   logic       rsp_free, s1_go, req_take;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && rsp_free;
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   // string state
   logic [MAX_PATTERN-1:0][7:0] win_ff, win_in, win_new;
   logic [POS_W-1:0]            pos_ff, pos_in, pos_new;
   logic                        rep_ff, rep_in;
   logic [LEN_W-1:0]            len_eff;
   logic                        bytes_eq, match;
   logic [IDX_W-1:0]            sel;
   logic [DIFF_W-1:0]           diff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   always_comb begin
      if (pat_len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (32'(pat_len_ff) > MAX_PATTERN) begin
         len_eff = LEN_W'(MAX_PATTERN);
      end else begin
         len_eff = LEN_W'(pat_len_ff);
      end
   end

   always_comb begin
      win_new[0] = s1_byte_ff;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         win_new[k] = win_ff[k-1];
      end
      pos_new = (32'(pos_ff) <= MAX_STRING) ? pos_ff + POS_W'(1) : pos_ff;
   end

   always_comb begin
      bytes_eq = 1'b1;
      sel      = '0;
      for (int unsigned i = 0; i < MAX_PATTERN; i++) begin
         sel = IDX_W'(len_eff - LEN_W'(1) - LEN_W'(i));
         if (LEN_W'(i) < len_eff && win_new[sel] != pat_byte(pattern, i)) begin
            bytes_eq = 1'b0;
         end
      end
      match = bytes_eq && (DIFF_W'(pos_new) >= DIFF_W'(len_eff))
              && (32'(pos_new) <= MAX_STRING);
      diff  = DIFF_W'(pos_new) - DIFF_W'(len_eff);
   end

   always_comb begin
      win_in       = win_ff;
      pos_in       = pos_ff;
      rep_in       = rep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      if (s1_go) begin
         if (!rep_ff) begin
            win_in = win_new;
            pos_in = pos_new;
            if (match) begin
               rep_in       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               rsp_index_in = INDEX_W'(diff);
            end else if (s1_last_ff) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b0;
               rsp_index_in = '0;
            end
         end
         if (s1_last_ff) begin
            win_in = '0;
            pos_in = '0;
            rep_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= '0;
         pos_ff       <= '0;
         rep_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         pos_ff       <= pos_in;
         rep_ff       <= rep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = rsp_index_ff;

endmodule

/* sim/substring_first_match_search_core_tb.sv */
// Testbench for substring_first_match_search_core: self-checking stream test with a predictor.
`timescale 1ns / 1ps

module substring_first_match_search_core_tb;
   import sfms_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 2_000_000;
   localparam int unsigned RANDOM_ITEMS  = 1400;
   localparam int unsigned SETTLE_CYCLES = 4;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [3:0] gap;
   } search_byte_t;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] index;
   } search_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = 8'd0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [INDEX_W-1:0]     rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   csr_index_type          csr_index = CSR_PATTERN_LOW;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   search_byte_t   byte_queue[$];
   search_result_t pending_results[$];

   // predictor state
   logic [63:0]               model_lo;
   logic [63:0]               model_hi;
   logic [PAT_LEN_W-1:0]      model_len;
   logic [PAT_BYTES-1:0][7:0] window_bytes;
   int unsigned               bytes_seen;
   bit                        reported;

   // stimulus state
   logic [127:0]          gen_pat;
   logic [PAT_LEN_W-1:0]  gen_len;
   logic [7:0]            alphabet [4];
   bit                    no_idle = 1'b0;
   int unsigned           queued_count = 0;
   int unsigned           mismatch_count = 0;
   int unsigned           cycle_count = 0;
   int unsigned           gap_left = 0;
   bit                    gap_armed = 1'b0;
   int unsigned           stall_left = 0;

   substring_first_match_search_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // data_byte
      .req_tlast  (req_tlast),   // last_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // match_index
      .rsp_tuser  (rsp_tuser),   // found
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   function automatic int unsigned eff_len(input logic [PAT_LEN_W-1:0] len_code);
      if (len_code == 0) return 1;
      if (len_code > PAT_BYTES) return PAT_BYTES;
      return int'(len_code);
   endfunction

   function automatic bit search_step(input logic [7:0] b, input logic last,
                                      output search_result_t res);
      int unsigned  len;
      bit           hit;
      bit           emit;
      logic [127:0] pat;
      pat  = {model_hi, model_lo};
      emit = 1'b0;
      res  = '0;
      if (!reported) begin
         len = eff_len(model_len);
         window_bytes = {window_bytes[PAT_BYTES-2:0], b};
         if (bytes_seen <= MAX_STRING_DEF) bytes_seen++;
         hit = bytes_seen >= len && bytes_seen <= MAX_STRING_DEF;
         for (int unsigned i = 0; i < len; i++)
            if (window_bytes[len-1-i] != pat[8*i +: 8]) hit = 1'b0;
         if (hit) begin
            res.found = 1'b1;
            res.index = INDEX_W'(bytes_seen - len);
            reported  = 1'b1;
            emit      = 1'b1;
         end else if (last) begin
            emit = 1'b1;
         end
      end
      if (last) begin
         window_bytes = '0;
         bytes_seen   = 0;
         reported     = 1'b0;
      end
      return emit;
   endfunction

   // input side: driver
   always @(posedge clock) begin
      search_byte_t cur;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_armed = 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (!gap_armed && byte_queue.size() != 0) begin
            gap_left  = byte_queue[0].gap;
            gap_armed = 1'b1;
         end
         if (gap_armed && gap_left == 0) begin
            cur = byte_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= cur.data;
            req_tlast  <= cur.last;
            gap_armed = 1'b0;
         end else begin
            req_tvalid <= 1'b0;
            if (gap_armed) gap_left--;
         end
      end
   end

   // accepted transfers and CSR writes feed the predictor
   always @(posedge clock) begin
      search_result_t res;
      if (reset) begin
         model_lo     = '0;
         model_hi     = '0;
         model_len    = PAT_LEN_W'(1);
         window_bytes = '0;
         bytes_seen   = 0;
         reported     = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PATTERN_LOW:  model_lo  = csr_data;
               CSR_PATTERN_HIGH: model_hi  = csr_data;
               CSR_PATTERN_LEN:  model_len = csr_data[PAT_LEN_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            if (search_step(req_tdata, req_tlast, res)) pending_results.push_back(res);
      end
   end

   // result side: backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) stall_left = no_idle ? 0 : $urandom_range(0, 8);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // result side: checker
   always @(posedge clock) begin
      search_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual found=%0b index=%0d",
                     $time, rsp_tuser, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.found) begin
               $display("%0t: found mismatch, expected %0b, actual %0b",
                        $time, want.found, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata !== want.index) begin
               $display("%0t: match_index mismatch, expected %0d, actual %0d",
                        $time, want.index, rsp_tdata);
               mismatch_count++;
            end
         end
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic last);
      search_byte_t item;
      item.data = b;
      item.last = last;
      item.gap  = no_idle ? 4'd0 : 4'($urandom_range(0, 8));
      byte_queue.push_back(item);
      queued_count++;
   endtask

   // wait until every transfer is in and every result is out
   task automatic drain();
      do @(negedge clock);
      while (byte_queue.size() != 0 || req_tvalid || pending_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_pattern(input logic [127:0] pat, input logic [PAT_LEN_W-1:0] len_code);
      logic [63:0]   vals [3];
      logic [63:0]   junk;
      csr_index_type regs [3];
      junk    = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
      vals[0] = pat[63:0];
      vals[1] = pat[127:64];
      vals[2] = {junk[63:PAT_LEN_W], len_code};
      regs    = '{CSR_PATTERN_LOW, CSR_PATTERN_HIGH, CSR_PATTERN_LEN};
      for (int k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[k];
         csr_data  <= vals[k];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      gen_pat = pat;
      gen_len = len_code;
   endtask

   task automatic random_pattern();
      logic [127:0]         pat;
      logic [PAT_LEN_W-1:0] len_code;
      int unsigned          sel;
      for (int k = 0; k < 4; k++) alphabet[k] = 8'($urandom_range(0, 255));
      pat = {$urandom, $urandom, $urandom, $urandom};
      sel = $urandom_range(0, 9);
      if (sel < 5)       len_code = PAT_LEN_W'($urandom_range(1, 4));
      else if (sel < 8)  len_code = PAT_LEN_W'($urandom_range(5, 16));
      else if (sel == 8) len_code = '0;
      else               len_code = PAT_LEN_W'($urandom_range(17, 31));
      for (int unsigned k = 0; k < eff_len(len_code); k++)
         pat[8*k +: 8] = alphabet[$urandom_range(0, 3)];
      load_pattern(pat, len_code);
   endtask

   // mostly strings over the pattern's alphabet with a (possibly cut) copy embedded
   task automatic queue_random_string(input bit terminate);
      int unsigned n, ins_at, eff, mode;
      logic [7:0]  b;
      eff    = eff_len(gen_len);
      mode   = $urandom_range(0, 9);
      n      = $urandom_range(1, 3 * eff + 8);
      ins_at = (mode < 6) ? $urandom_range(0, n - 1) : n;
      for (int unsigned k = 0; k < n; k++) begin
         if (k >= ins_at && k - ins_at < eff) b = gen_pat[8*(k-ins_at) +: 8];
         else if (mode == 9)                 b = 8'($urandom_range(0, 255));
         else                                b = alphabet[$urandom_range(0, 3)];
         push_byte(b, terminate && k == n - 1);
      end
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("substring_first_match_search_core test failed");
      $finish;
   end

   initial begin
      int unsigned phase, phase_start, phase_target;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset pattern: one zero byte
      push_byte(8'h00, 1'b1);
      drain();

      load_pattern(128'h636261, 5'd3);
      push_byte(8'h61, 1'b0);
      push_byte(8'h62, 1'b0);
      push_byte(8'h61, 1'b0);
      push_byte(8'h62, 1'b0);
      push_byte(8'h63, 1'b0);
      push_byte(8'h7A, 1'b1);
      push_byte(8'h61, 1'b0);   // shorter than pattern
      push_byte(8'h62, 1'b1);
      push_byte(8'h61, 1'b0);   // string left open across the pattern change
      drain();

      load_pattern(128'hFF, 5'd0);
      push_byte(8'hFF, 1'b1);
      drain();

      // length above max, match on the last byte
      load_pattern(128'hFEDCBA9876543210_0123456789ABCDEF, 5'd31);
      for (int unsigned k = 0; k < PAT_BYTES; k++)
         push_byte(gen_pat[8*k +: 8], k == PAT_BYTES - 1);
      drain();

      phase = 0;
      phase_start = queued_count;
      while (queued_count - phase_start < RANDOM_ITEMS) begin
         no_idle = (phase % 4 == 3);
         random_pattern();
         phase_target = queued_count + $urandom_range(120, 220);
         while (queued_count < phase_target) queue_random_string(1'b1);
         if ($urandom_range(0, 9) < 3) queue_random_string(1'b0);
         drain();
         phase++;
      end
      queue_random_string(1'b1);
      drain();

      if (mismatch_count == 0)
         $display("substring_first_match_search_core test passed");
      else
         $display("substring_first_match_search_core test failed");
      $finish;
   end

endmodule
